// File: sv/combination_unranker_defines.svh
// Assertion macros used by the checker file of the unranker.
// No dependencies.
`ifndef COMBINATION_UNRANKER_DEFINES_SVH
`define COMBINATION_UNRANKER_DEFINES_SVH

// Property checked on every edge outside reset.
`define CU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define CU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/cu_pkg.sv
// Shared widths, constants and structs for the combination unranker.
// No dependencies.
package cu_pkg;

  localparam int SizeW = 5;
  localparam int RankW = 31;
  localparam int ElemW = 31;
  localparam int ArgW  = 32;   // binomial n argument, up to k + rank
  localparam int BinW  = 33;   // saturated binomial, up to 2^32
  localparam int ProdW = 64;   // c * (m + i)
  localparam int DivBitsPerCycle = 8;
  localparam int DivCycles = ProdW / DivBitsPerCycle;
  localparam int DivCntW = $clog2(DivCycles);

  localparam logic [BinW-1:0] BinCap = {1'b1, {(BinW-1){1'b0}}};

  typedef struct packed {
    logic [SizeW-1:0] k;
    logic [RankW-1:0] rank;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [ArgW-1:0]  n;
    logic [SizeW-1:0] k;
  } binom_req_t;

  typedef struct packed {
    logic            done;
    logic [BinW-1:0] value;
  } binom_rsp_t;

endpackage

// File: sv/cu_ifs.sv
// Valid/ready channel interfaces for the unranker command and result streams.
// Depends on cu_pkg.
interface cu_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [cu_pkg::SizeW-1:0]      combination_size;
  logic [cu_pkg::RankW-1:0]      rank;
  modport source(output valid, combination_size, rank, input ready);
  modport sink(input valid, combination_size, rank, output ready);
endinterface

interface cu_res_if;
  logic                          valid;
  logic                          ready;
  logic [cu_pkg::ElemW-1:0]      element;
  logic                          last;
  modport source(output valid, element, last, input ready);
  modport sink(input valid, element, last, output ready);
endinterface

// File: sv/cu_front.sv
// Front end: accepts commands, clamps k, drops empty jobs, two-entry queue.
// Depends on cu_pkg and cu_ifs.
module cu_front #(
  parameter int K_MAX = 16
) (
  input  logic         clk,
  input  logic         rst,
  cu_cmd_if.sink       cmd,
  output cu_pkg::job_t job,
  output logic         job_valid,
  input  logic         job_pop
);

  cu_pkg::job_t              queue [2];
  logic                      wr_ptr;
  logic                      rd_ptr;
  logic [1:0]                count;
  logic [cu_pkg::SizeW-1:0]  k_clamped;
  logic                      push;

  assign k_clamped = (32'(cmd.combination_size) > K_MAX) ? cu_pkg::SizeW'(K_MAX)
                                                         : cmd.combination_size;
  assign cmd.ready = (count != 2'd2);
  // size zero makes no results: accepted, never queued
  assign push      = cmd.valid && cmd.ready && (k_clamped != '0);
  assign job_valid = (count != 2'd0);
  assign job       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{k: k_clamped, rank: cmd.rank};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (job_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(job_pop);
    end
  end

endmodule

// File: sv/cu_binom.sv
// Iterative saturating binomial C(n,k): one multiply, then an 8-bit/cycle divide.
// Depends on cu_pkg.
module cu_binom (
  input  logic               clk,
  input  logic               rst,
  input  cu_pkg::binom_req_t req,
  output cu_pkg::binom_rsp_t rsp
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_DIV  = 3'b100
  } bstate_t;

  bstate_t                     state;
  logic [cu_pkg::ArgW-1:0]     m;
  logic [cu_pkg::SizeW-1:0]    kk;
  logic [cu_pkg::SizeW-1:0]    i;
  logic [cu_pkg::BinW-1:0]     c;
  logic [cu_pkg::ProdW-1:0]    prod;
  logic [cu_pkg::SizeW-1:0]    rem;
  logic [cu_pkg::DivCntW-1:0]  cnt;
  logic [cu_pkg::ProdW-1:0]    q_next;
  logic [cu_pkg::SizeW-1:0]    rem_next;

  // restoring division, eight quotient bits per cycle
  always_comb begin
    logic [cu_pkg::SizeW:0] r2;
    q_next   = prod;
    rem_next = rem;
    for (int j = 0; j < cu_pkg::DivBitsPerCycle; j++) begin
      r2     = {rem_next, q_next[cu_pkg::ProdW-1]};
      q_next = {q_next[cu_pkg::ProdW-2:0], 1'b0};
      if (r2 >= {1'b0, i}) begin
        r2        = r2 - {1'b0, i};
        q_next[0] = 1'b1;
      end
      rem_next = r2[cu_pkg::SizeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (req.start) begin
            if (req.n < cu_pkg::ArgW'(req.k)) begin
              rsp.done  <= 1'b1;
              rsp.value <= '0;
            end else begin
              m     <= req.n - cu_pkg::ArgW'(req.k);
              kk    <= req.k;
              i     <= cu_pkg::SizeW'(1);
              c     <= cu_pkg::BinW'(1);
              state <= B_MUL;
            end
          end
        end
        B_MUL: begin
          prod  <= cu_pkg::ProdW'(c) * cu_pkg::ProdW'(m + cu_pkg::ArgW'(i));
          rem   <= '0;
          cnt   <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          prod <= q_next;
          rem  <= rem_next;
          cnt  <= cnt + 1'b1;
          if (cnt == cu_pkg::DivCntW'(cu_pkg::DivCycles - 1)) begin
            if (q_next > cu_pkg::ProdW'(cu_pkg::BinCap)) begin
              rsp.done  <= 1'b1;
              rsp.value <= cu_pkg::BinCap;
              state     <= B_IDLE;
            end else if (i == kk) begin
              rsp.done  <= 1'b1;
              rsp.value <= q_next[cu_pkg::BinW-1:0];
              state     <= B_IDLE;
            end else begin
              c     <= q_next[cu_pkg::BinW-1:0];
              i     <= i + 1'b1;
              state <= B_MUL;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: sv/cu_back.sv
// Back end: per-element binary search for the largest n with C(n,k) <= rank.
// Depends on cu_pkg, cu_ifs and cu_binom.
module cu_back (
  input  logic         clk,
  input  logic         rst,
  input  cu_pkg::job_t job,
  input  logic         job_valid,
  output logic         job_pop,
  cu_res_if.source     res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_PROBE = 5'b00100,
    S_WAIT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                    state;
  logic [cu_pkg::SizeW-1:0]  k;
  logic [cu_pkg::RankW-1:0]  rank;
  logic [cu_pkg::ArgW-1:0]   lo;
  logic [cu_pkg::ArgW-1:0]   hi;
  logic [cu_pkg::ArgW-1:0]   mid;
  logic [cu_pkg::BinW-1:0]   clo;
  logic [cu_pkg::ArgW-1:0]   span;
  cu_pkg::binom_req_t        breq;
  cu_pkg::binom_rsp_t        brsp;
  logic                      out_load;

  cu_binom u_binom (
    .clk (clk),
    .rst (rst),
    .req (breq),
    .rsp (brsp)
  );

  assign span      = hi - lo;
  assign job_pop   = (state == S_IDLE) && job_valid;
  assign out_load  = (state == S_EMIT) && (!res.valid || res.ready);
  assign breq.start = (state == S_PROBE) && (span > cu_pkg::ArgW'(1));
  assign breq.n     = lo + (span >> 1);
  assign breq.k     = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (out_load) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            k     <= job.k;
            rank  <= job.rank;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          lo    <= cu_pkg::ArgW'(k) - 1'b1;     // C(k-1,k) = 0
          hi    <= cu_pkg::ArgW'(k) + cu_pkg::ArgW'(rank);
          clo   <= '0;
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (breq.start) begin
            mid   <= breq.n;
            state <= S_WAIT;
          end else begin
            state <= S_EMIT;
          end
        end
        S_WAIT: begin
          if (brsp.done) begin
            if (brsp.value <= cu_pkg::BinW'(rank)) begin
              lo  <= mid;
              clo <= brsp.value;
            end else begin
              hi <= mid;
            end
            state <= S_PROBE;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            res.element <= lo[cu_pkg::ElemW-1:0];
            res.last    <= (k == cu_pkg::SizeW'(1));
            rank        <= rank - clo[cu_pkg::RankW-1:0];
            k           <= k - 1'b1;
            state       <= (k == cu_pkg::SizeW'(1)) ? S_IDLE : S_SETUP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/combination_unranker.sv
// Top level of the combination unranker: front end, job queue and search back end.
// Depends on cu_pkg, cu_ifs, cu_front and cu_back.
//
// Takes a size k and a rank and returns the k-combination at that rank in the
// combinatorial number system, largest element first, with last set on the
// final one. k is clamped to K_MAX; k of zero is accepted and yields nothing.
// Each element is found by a binary search over n (about log2(rank+1) probes,
// at most 31); each probe evaluates a saturating C(n,k) in the single binomial
// unit, one factor at a time: a multiply step, then an iterated divide by the
// factor index. The binomial unit sets the rate; one job is worked at a time
// while the front end queues up to two more, and the registered result output
// lets the next element be computed while the previous transaction waits on
// ready.
module combination_unranker #(
  parameter int K_MAX = 16
) (
  input  logic     clk,
  input  logic     rst,
  cu_cmd_if.sink   cmd,
  cu_res_if.source res
);

  cu_pkg::job_t job;
  logic         job_valid;
  logic         job_pop;

  // front: clamp, drop empty jobs, buffer
  cu_front #(.K_MAX(K_MAX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop)
  );

  // back: element search and result register
  cu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .res       (res)
  );

endmodule

// File: sv/cu_checker.sv
// Port-level checks for the combination unranker, bound to the top level.
// Depends on combination_unranker_defines.svh.
`include "combination_unranker_defines.svh"

module cu_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [30:0] res_element,
  input logic        res_last
);

  `CU_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !res_valid, "result valid after reset")
  `CU_ASSERT(a_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_element) && $stable(res_last), "stalled result changed")
  `CU_ASSERT(a_nonzero, clk, rst, res_valid && !res_last |-> res_element != 31'd0, "zero element before last")

endmodule

bind combination_unranker cu_checker u_cu_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_element (res.element),
  .res_last    (res.last)
);
